[sv/pfc_pkg.sv]
// ----------------------------------------------------------------------------
// pfc_pkg
// Shared constants, codes and types of the packet frame checker.
// ----------------------------------------------------------------------------
`default_nettype none

package pfc_pkg;

  // Header layout: big-endian fields, checksum in the last four bytes.
  localparam int HeaderLen = 28;
  localparam int CheckAt   = 24;
  localparam int HdrIdxW   = $clog2(HeaderLen);

  // The byte counter saturates at its all-ones value.
  localparam int CountW = 17;
  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  // FNV-1a 32 offset basis and prime.
  localparam logic [31:0] FnvStart = 32'd2166136261;
  localparam logic [31:0] FnvPrime = 32'd16777619;

  // Configuration port geometry.
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MAGIC         = 3'd0,
    REG_VERSION       = 3'd1,
    REG_CHECK_VERSION = 3'd2,
    REG_TYPE_LOWEST   = 3'd3,
    REG_TYPE_HIGHEST  = 3'd4,
    REG_PAYLOAD_LIMIT = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_ACCEPTED = 2'd0,
    ST_MALFORMED = 2'd1,
    ST_MISMATCH  = 2'd2
  } status_t;

  // One result word as it waits in the output buffer.
  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic        verdict_valid;
    logic [1:0]  status;
    logic [15:0] version;
    logic [15:0] packet_type;
    logic [31:0] session_id;
    logic [7:0]  player_id;
    logic [7:0]  flag_bits;
    logic [31:0] sequence_number;
    logic [31:0] frame_number;
    logic [15:0] payload_length;
  } result_t;

  // One FNV-1a 32 step: xor in the byte, then multiply by the prime.
  function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
    logic [31:0] x;
    x = h ^ {24'd0, b};
    fnv_step = x * FnvPrime;
  endfunction

endpackage

`default_nettype wire

[sv/pfc_in_if.sv]
// ----------------------------------------------------------------------------
// pfc_in_if
// Byte stream channel: one packet byte per word, with an end-of-packet flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface pfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

[sv/pfc_out_if.sv]
// ----------------------------------------------------------------------------
// pfc_out_if
// Result channel: passed-through payload bytes and the per-packet verdict.
// ----------------------------------------------------------------------------
`default_nettype none

interface pfc_out_if;
  logic        valid;
  logic        ready;
  logic        payload_valid;
  logic [7:0]  payload_byte;
  logic        verdict_valid;
  logic [1:0]  status;
  logic [15:0] version;
  logic [15:0] packet_type;
  logic [31:0] session_id;
  logic [7:0]  player_id;
  logic [7:0]  flag_bits;
  logic [31:0] sequence_number;
  logic [31:0] frame_number;
  logic [15:0] payload_length;

  modport source (
    output valid, output payload_valid, output payload_byte, output verdict_valid,
    output status, output version, output packet_type, output session_id,
    output player_id, output flag_bits, output sequence_number, output frame_number,
    output payload_length, input ready
  );
  modport sink (
    input valid, input payload_valid, input payload_byte, input verdict_valid,
    input status, input version, input packet_type, input session_id,
    input player_id, input flag_bits, input sequence_number, input frame_number,
    input payload_length, output ready
  );
endinterface

`default_nettype wire

[sv/pfc_cfg_if.sv]
// ----------------------------------------------------------------------------
// pfc_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface pfc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[sv/packet_frame_checker_unit.sv]
// ----------------------------------------------------------------------------
// packet_frame_checker_unit
// Deframes a byte stream into 28-byte header plus payload, runs FNV-1a 32
// over header bytes 0..23 and the payload, and gives a verdict per packet.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Word
//  -------  ---------  ----------------------------------------------------
//  packet   sink       data_byte, last_byte
//  result   source     payload byte and/or verdict with header fields
//  cfg      sink       index, data (register write, always ready)
//
//  One word is taken per cycle while packet.ready is high; its result is
//  registered into the output buffer, so throughput is one byte per cycle.
//  The hash multiply and the header compare path set the cycle time.
//  A two-entry output buffer lets the packet side run on while one result
//  waits; packet.ready drops only when both entries are full.
//  Synchronous reset clears the counters, hash, registers and buffer state;
//  header byte storage is not reset and is rewritten by every packet.
//
`default_nettype none

module packet_frame_checker_unit import pfc_pkg::*; (
  input  wire       clk,
  input  wire       rst,
  pfc_in_if.sink    packet,
  pfc_out_if.source result,
  pfc_cfg_if.sink   cfg
);

  // Configuration registers.
  logic [31:0] magic_word;
  logic [15:0] current_version;
  logic        check_version;
  logic [15:0] type_lowest;
  logic [15:0] type_highest;
  logic [15:0] payload_limit;

  // Parser state.
  logic [CountW-1:0] byte_count;
  logic [31:0]       running_hash;
  logic [7:0]        header_bytes [HeaderLen];

  // Output buffer: main register and skid register.
  logic    out_valid;
  result_t out_res;
  logic    skid_valid;
  result_t skid_res;

  // Combinational signals.
  logic              accept;
  logic              pop;
  logic              push;
  logic              in_header;
  logic              in_payload;
  logic              in_hashed;
  logic [HdrIdxW-1:0] hdr_idx;
  logic [7:0]        hdr_next [HeaderLen];
  logic [CountW-1:0] byte_count_next;
  logic [31:0]       running_hash_next;
  logic [31:0]       magic_rx;
  logic [31:0]       check_rx;
  logic [15:0]       version_rx;
  logic [15:0]       type_rx;
  logic [15:0]       length_rx;
  logic [CountW-1:0] expected_count;
  logic              is_short;
  status_t           status_sel;
  result_t           res_new;

  // Configuration writes are always taken; unknown indexes are dropped.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      magic_word      <= '0;
      current_version <= '0;
      check_version   <= 1'b1;
      type_lowest     <= '0;
      type_highest    <= 16'd24;
      payload_limit   <= 16'd1024;
    end else if (cfg.valid) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_MAGIC:         magic_word      <= cfg.data;
        REG_VERSION:       current_version <= cfg.data[15:0];
        REG_CHECK_VERSION: check_version   <= cfg.data[0];
        REG_TYPE_LOWEST:   type_lowest     <= cfg.data[15:0];
        REG_TYPE_HIGHEST:  type_highest    <= cfg.data[15:0];
        REG_PAYLOAD_LIMIT: payload_limit   <= cfg.data[15:0];
        default: ;
      endcase
    end
  end

  // Handshake: stall the packet side only when both buffer entries hold data.
  assign packet.ready = !skid_valid;
  assign accept       = packet.valid && packet.ready;
  assign pop          = out_valid && result.ready;

  // Position of the current byte within the packet.
  assign in_header  = byte_count < CountW'(HeaderLen);
  assign in_payload = !in_header;
  assign in_hashed  = (byte_count < CountW'(CheckAt)) || in_payload;
  assign hdr_idx    = byte_count[HdrIdxW-1:0];

  // Header view with the current byte folded in.
  always_comb begin
    for (int i = 0; i < HeaderLen; i++) begin
      hdr_next[i] = (in_header && hdr_idx == HdrIdxW'(i)) ? packet.data_byte
                                                          : header_bytes[i];
    end
  end

  // Next count and hash.
  assign byte_count_next   = (byte_count == CountMax) ? byte_count
                                                      : byte_count + 1'b1;
  assign running_hash_next = in_hashed ? fnv_step(running_hash, packet.data_byte)
                                       : running_hash;

  // Header field extraction.
  assign magic_rx   = {hdr_next[0], hdr_next[1], hdr_next[2], hdr_next[3]};
  assign version_rx = {hdr_next[4], hdr_next[5]};
  assign type_rx    = {hdr_next[6], hdr_next[7]};
  assign length_rx  = {hdr_next[22], hdr_next[23]};
  assign check_rx   = {hdr_next[24], hdr_next[25], hdr_next[26], hdr_next[27]};

  assign expected_count = CountW'(HeaderLen) + {1'b0, length_rx};
  assign is_short       = byte_count_next < CountW'(HeaderLen);

  // Verdict, first failing check decides.
  always_comb begin
    if (is_short) begin
      status_sel = ST_MALFORMED;
    end else if (magic_rx != magic_word || type_rx < type_lowest
                 || type_rx > type_highest) begin
      status_sel = ST_MALFORMED;
    end else if (check_version && version_rx != current_version) begin
      status_sel = ST_MISMATCH;
    end else if (length_rx > payload_limit || byte_count_next != expected_count) begin
      status_sel = ST_MALFORMED;
    end else if (check_rx != running_hash_next) begin
      status_sel = ST_MALFORMED;
    end else begin
      status_sel = ST_ACCEPTED;
    end
  end

  // Assemble the result word; fields are zero where they do not apply.
  always_comb begin
    res_new = '0;
    if (in_payload) begin
      res_new.payload_valid = 1'b1;
      res_new.payload_byte  = packet.data_byte;
    end
    if (packet.last_byte) begin
      res_new.verdict_valid = 1'b1;
      res_new.status        = status_sel;
      if (!is_short) begin
        res_new.version         = version_rx;
        res_new.packet_type     = type_rx;
        res_new.session_id      = {hdr_next[8], hdr_next[9], hdr_next[10], hdr_next[11]};
        res_new.player_id       = hdr_next[12];
        res_new.flag_bits       = hdr_next[13];
        res_new.sequence_number = {hdr_next[14], hdr_next[15], hdr_next[16], hdr_next[17]};
        res_new.frame_number    = {hdr_next[18], hdr_next[19], hdr_next[20], hdr_next[21]};
        res_new.payload_length  = length_rx;
      end
    end
  end

  assign push = accept && (in_payload || packet.last_byte);

  // Parser state update; a packet end restarts the count and hash.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count   <= '0;
      running_hash <= FnvStart;
    end else if (accept) begin
      if (packet.last_byte) begin
        byte_count   <= '0;
        running_hash <= FnvStart;
      end else begin
        byte_count   <= byte_count_next;
        running_hash <= running_hash_next;
      end
    end
  end

  // Header byte storage.
  always_ff @(posedge clk) begin
    if (accept && in_header) begin
      header_bytes[hdr_idx] <= packet.data_byte;
    end
  end

  // Output buffer control.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  // Output buffer data.
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_res <= skid_res;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_res <= res_new;
      end else begin
        skid_res <= res_new;
      end
    end
  end

  // Drive the result channel.
  assign result.valid           = out_valid;
  assign result.payload_valid   = out_res.payload_valid;
  assign result.payload_byte    = out_res.payload_byte;
  assign result.verdict_valid   = out_res.verdict_valid;
  assign result.status          = out_res.status;
  assign result.version         = out_res.version;
  assign result.packet_type     = out_res.packet_type;
  assign result.session_id      = out_res.session_id;
  assign result.player_id       = out_res.player_id;
  assign result.flag_bits       = out_res.flag_bits;
  assign result.sequence_number = out_res.sequence_number;
  assign result.frame_number    = out_res.frame_number;
  assign result.payload_length  = out_res.payload_length;

`ifndef NO_ASSERTIONS
  // The skid entry is only ever filled behind a full main entry.
  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry holds data while main entry is empty");

  // A word that ends a packet restarts the byte count.
  a_count_restart: assert property (@(posedge clk) disable iff (rst)
    (accept && packet.last_byte) |=> byte_count == '0)
    else $error("byte count did not restart after end of packet");

  // A word that ends a packet reloads the hash with the offset basis.
  a_hash_reload: assert property (@(posedge clk) disable iff (rst)
    (accept && packet.last_byte) |=> running_hash == FnvStart)
    else $error("hash not reloaded after end of packet");

  // Every shown word carries a payload byte or a verdict.
  a_result_nonempty: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_res.payload_valid || out_res.verdict_valid))
    else $error("empty result word on output");

  // Verdict status is never the unused code.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.verdict_valid) |-> out_res.status != 2'b11)
    else $error("verdict carries an unused status code");
`endif

endmodule

`default_nettype wire

[dv/tb_packet_frame_checker_unit.sv]
// ----------------------------------------------------------------------------
// tb_packet_frame_checker_unit
// Self-checking bench for the packet frame checker. Byte streams are built
// with real FNV-1a 32 checksums and sent through a stalling driver. Each
// accepted byte runs through an in-bench deframer that predicts the payload
// and verdict words. A monitor with random back-pressure compares them
// field by field. Directed frames come first, then random frames under
// random register settings.
// ----------------------------------------------------------------------------
module tb_packet_frame_checker_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import pfc_pkg::*;

  // Byte offsets of the big-endian header fields.
  localparam int OffMagic   = 0;
  localparam int OffVersion = 4;
  localparam int OffType    = 6;
  localparam int OffSession = 8;
  localparam int OffPlayer  = 12;
  localparam int OffFlags   = 13;
  localparam int OffSeq     = 14;
  localparam int OffFrame   = 18;
  localparam int OffLength  = 22;

  // Register indexes beyond the defined set; writes to them are dropped.
  localparam logic [CfgIdxW-1:0] RegSpareLo = 3'd6;
  localparam logic [CfgIdxW-1:0] RegSpareHi = 3'd7;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } wire_byte_t;

  typedef struct packed {
    logic [31:0] magic;
    logic [15:0] ver;
    logic [15:0] ptype;
    logic [31:0] session;
    logic [7:0]  player;
    logic [7:0]  flags;
    logic [31:0] seqno;
    logic [31:0] frame;
    logic [15:0] len_field;
  } frame_hdr_t;

  logic clk;
  logic rst;

  pfc_in_if  pkt_ch ();
  pfc_out_if res_ch ();
  pfc_cfg_if cfg_ch ();

  packet_frame_checker_unit uut (
    .clk    (clk),
    .rst    (rst),
    .packet (pkt_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  // Bench copy of the registers.
  logic [31:0] want_magic;
  logic [15:0] want_version;
  logic        want_check_ver;
  logic [15:0] want_type_lo;
  logic [15:0] want_type_hi;
  logic [15:0] want_limit;

  // Deframer state mirrored from the block.
  logic [CountW-1:0] frame_count;
  logic [31:0]       frame_hash;
  logic [7:0]        hdr_store [HeaderLen];

  wire_byte_t bytes_pending [$];
  result_t    words_due [$];

  int   mismatches;
  int   words_seen;
  int   bytes_taken;
  int   src_idle_odds;
  int   sink_idle_odds;
  int   src_gap;
  int   sink_gap;
  int   hold_from;
  logic long_hold;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Guard against a hung block.
  initial begin : watchdog
    #2_000_000;
    $display("FAIL packet_frame_checker_unit");
    $finish;
  end

  // One FNV-1a 32 round over a byte.
  function automatic logic [31:0] fnv1a_mix(input logic [31:0] h, input logic [7:0] b);
    logic [31:0] x;
    x = h ^ {24'd0, b};
    return x * 32'd16777619;
  endfunction

  function automatic logic [15:0] hdr16(input int at);
    return {hdr_store[at], hdr_store[at + 1]};
  endfunction

  function automatic logic [31:0] hdr32(input int at);
    return {hdr16(at), hdr16(at + 2)};
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("[%0t] mismatch at result word %0d: %s", $time, words_seen, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      flag_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    end
  endtask

  // Deframe one accepted byte and queue the word it should produce, if any.
  task automatic deframe_byte(input logic [7:0] b, input logic last);
    result_t           r;
    logic [CountW-1:0] off;
    logic              at_payload;
    logic [15:0]       ver;
    logic [15:0]       ptype;
    logic [15:0]       plen;
    off = frame_count;
    at_payload = (off >= HeaderLen);
    r = '0;
    if (!at_payload) begin
      hdr_store[off] = b;
    end
    if (off < CheckAt || at_payload) begin
      frame_hash = fnv1a_mix(frame_hash, b);
    end
    if (frame_count != CountMax) begin
      frame_count = frame_count + 1'b1;
    end
    if (at_payload) begin
      r.payload_valid = 1'b1;
      r.payload_byte  = b;
    end
    if (last) begin
      r.verdict_valid = 1'b1;
      if (frame_count < HeaderLen) begin
        r.status = ST_MALFORMED;
      end else begin
        ver   = hdr16(OffVersion);
        ptype = hdr16(OffType);
        plen  = hdr16(OffLength);
        // The first failing check decides the verdict.
        if (hdr32(OffMagic) != want_magic || ptype < want_type_lo || ptype > want_type_hi) begin
          r.status = ST_MALFORMED;
        end else if (want_check_ver && ver != want_version) begin
          r.status = ST_MISMATCH;
        end else if (plen > want_limit || frame_count != HeaderLen + plen) begin
          r.status = ST_MALFORMED;
        end else if (hdr32(CheckAt) != frame_hash) begin
          r.status = ST_MALFORMED;
        end else begin
          r.status = ST_ACCEPTED;
        end
        r.version         = ver;
        r.packet_type     = ptype;
        r.session_id      = hdr32(OffSession);
        r.player_id       = hdr_store[OffPlayer];
        r.flag_bits       = hdr_store[OffFlags];
        r.sequence_number = hdr32(OffSeq);
        r.frame_number    = hdr32(OffFrame);
        r.payload_length  = plen;
      end
      frame_count = '0;
      frame_hash  = FnvStart;
    end
    if (at_payload || last) begin
      words_due = {words_due, r};
    end
  endtask

  // Byte driver: offers queued bytes, with random idle bursts.
  always @(posedge clk) begin : drive_bytes
    logic       offer;
    wire_byte_t nxt;
    if (rst) begin
      pkt_ch.valid <= 1'b0;
      src_gap = 0;
    end else begin
      if (pkt_ch.valid && pkt_ch.ready) begin
        deframe_byte(pkt_ch.data_byte, pkt_ch.last_byte);
        bytes_taken++;
      end
      if (!pkt_ch.valid || pkt_ch.ready) begin
        offer = 1'b0;
        if (src_gap != 0) begin
          src_gap--;
        end else if (src_idle_odds != 0 && $urandom_range(1, src_idle_odds) == 1) begin
          src_gap = $urandom_range(0, 11);
        end else if (bytes_pending.size() != 0) begin
          offer = 1'b1;
        end
        if (offer) begin
          nxt = bytes_pending.pop_front();
          pkt_ch.data_byte <= nxt.data;
          pkt_ch.last_byte <= nxt.last;
        end
        pkt_ch.valid <= offer;
      end
    end
  end

  // Result monitor: checks each accepted word and applies back-pressure.
  always @(posedge clk) begin : watch_results
    result_t want;
    logic    take;
    if (rst) begin
      res_ch.ready <= 1'b0;
      sink_gap = 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (words_due.size() == 0) begin
          flag_mismatch("result word with nothing expected");
        end else begin
          want = words_due.pop_front();
          check_field("payload_valid", 32'(res_ch.payload_valid), 32'(want.payload_valid));
          check_field("payload_byte", 32'(res_ch.payload_byte), 32'(want.payload_byte));
          check_field("verdict_valid", 32'(res_ch.verdict_valid), 32'(want.verdict_valid));
          check_field("status", 32'(res_ch.status), 32'(want.status));
          check_field("version", 32'(res_ch.version), 32'(want.version));
          check_field("packet_type", 32'(res_ch.packet_type), 32'(want.packet_type));
          check_field("session_id", res_ch.session_id, want.session_id);
          check_field("player_id", 32'(res_ch.player_id), 32'(want.player_id));
          check_field("flag_bits", 32'(res_ch.flag_bits), 32'(want.flag_bits));
          check_field("sequence_number", res_ch.sequence_number, want.sequence_number);
          check_field("frame_number", res_ch.frame_number, want.frame_number);
          check_field("payload_length", 32'(res_ch.payload_length),
                      32'(want.payload_length));
        end
        words_seen++;
      end
      take = 1'b1;
      if (sink_gap != 0) begin
        sink_gap--;
        take = 1'b0;
      end else if (sink_idle_odds != 0 && $urandom_range(1, sink_idle_odds) == 1) begin
        sink_gap = $urandom_range(0, 11);
        take = 1'b0;
      end
      res_ch.ready <= take && !long_hold;
    end
  end

  // One long receiver hold-off while the sender keeps offering bytes.
  initial begin : hold_results
    long_hold = 1'b0;
    wait (hold_from != 0);
    wait (bytes_taken >= hold_from);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (160) @(posedge clk);
    long_hold <= 1'b0;
  end

  // Register write; the bench copy follows once the write is taken.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (cfg_ch.ready !== 1'b1) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_MAGIC:         want_magic     = val;
      REG_VERSION:       want_version   = val[15:0];
      REG_CHECK_VERSION: want_check_ver = val[0];
      REG_TYPE_LOWEST:   want_type_lo   = val[15:0];
      REG_TYPE_HIGHEST:  want_type_hi   = val[15:0];
      REG_PAYLOAD_LIMIT: want_limit     = val[15:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Wait until every byte is sent and every word checked, then let the
  // block drain its pipeline.
  task automatic settle;
    while (bytes_pending.size() != 0 || pkt_ch.valid || words_due.size() != 0) begin
      @(negedge clk);
    end
    repeat (8) @(negedge clk);
  endtask

  task automatic set_idling(input int src_odds, input int sink_odds);
    src_idle_odds  = src_odds;
    sink_idle_odds = sink_odds;
  endtask

  // A header that passes every check under the current registers, unless the type window is empty.
  function automatic frame_hdr_t good_hdr(input int max_pay);
    frame_hdr_t h;
    int         cap;
    h.magic = want_magic;
    h.ver   = want_check_ver ? want_version : 16'($urandom);
    if (want_type_lo <= want_type_hi) begin
      h.ptype = 16'($urandom_range(want_type_hi, want_type_lo));
    end else begin
      h.ptype = 16'($urandom);
    end
    h.session = $urandom;
    h.player  = 8'($urandom);
    h.flags   = 8'($urandom);
    h.seqno   = $urandom;
    h.frame   = $urandom;
    cap = (int'(want_limit) < max_pay) ? int'(want_limit) : max_pay;
    h.len_field = 16'($urandom_range(cap, 0));
    return h;
  endfunction

  // Serialise a frame with its checksum; cut truncates it to that many bytes.
  task automatic queue_frame(input frame_hdr_t h, input int pay_count, input logic bad_sum,
                             input int cut);
    logic [7:0]  hb [HeaderLen];
    logic [7:0]  pay [];
    logic [31:0] sum;
    int          total;
    wire_byte_t  w;
    {hb[0], hb[1], hb[2], hb[3]}     = h.magic;
    {hb[4], hb[5]}                   = h.ver;
    {hb[6], hb[7]}                   = h.ptype;
    {hb[8], hb[9], hb[10], hb[11]}   = h.session;
    hb[12]                           = h.player;
    hb[13]                           = h.flags;
    {hb[14], hb[15], hb[16], hb[17]} = h.seqno;
    {hb[18], hb[19], hb[20], hb[21]} = h.frame;
    {hb[22], hb[23]}                 = h.len_field;
    pay = new[pay_count];
    sum = FnvStart;
    for (int i = 0; i < CheckAt; i++) sum = fnv1a_mix(sum, hb[i]);
    foreach (pay[i]) begin
      pay[i] = 8'($urandom);
      sum = fnv1a_mix(sum, pay[i]);
    end
    if (bad_sum) begin
      sum ^= 32'h1 << $urandom_range(0, 31);
    end
    {hb[24], hb[25], hb[26], hb[27]} = sum;
    total = HeaderLen + pay_count;
    if (cut > 0 && cut < total) total = cut;
    for (int i = 0; i < total; i++) begin
      if (i < HeaderLen) begin
        w.data = hb[i];
      end else begin
        w.data = pay[i - HeaderLen];
      end
      w.last = (i == total - 1);
      bytes_pending = {bytes_pending, w};
    end
  endtask

  task automatic queue_noise;
    wire_byte_t w;
    int         n;
    n = $urandom_range(1, 40);
    for (int i = 0; i < n; i++) begin
      w.data = 8'($urandom);
      w.last = (i == n - 1);
      bytes_pending = {bytes_pending, w};
    end
  endtask

  // Mostly well-formed frames with random content, the rest broken in one
  // way or plain noise.
  task automatic queue_random_frame(input int max_pay);
    frame_hdr_t h;
    int         pay;
    int         cut;
    logic       bad_sum;
    h = good_hdr(max_pay);
    pay = int'(h.len_field);
    cut = 0;
    bad_sum = 1'b0;
    case ($urandom_range(0, 19))
      0: h.magic ^= 32'h1 << $urandom_range(0, 31);
      1: begin
        if (want_type_hi != 16'hFFFF) begin
          h.ptype = 16'($urandom_range(16'hFFFF, want_type_hi + 16'd1));
        end else if (want_type_lo != 16'd0) begin
          h.ptype = 16'($urandom_range(want_type_lo - 16'd1, 0));
        end
      end
      2: h.ver = want_version ^ (16'h1 << $urandom_range(0, 15));
      3: pay = pay + 1;
      4: pay = (pay > 0) ? pay - 1 : 1;
      5: bad_sum = 1'b1;
      6: cut = $urandom_range(1, HeaderLen + pay);
      7: begin
        if (want_limit != 16'hFFFF) begin
          h.len_field = want_limit + 16'd1;
          if (h.len_field <= 40) pay = int'(h.len_field);
        end
      end
      8: begin
        queue_noise();
        return;
      end
      default: ;
    endcase
    queue_frame(h, pay, bad_sum, cut);
  endtask

  task automatic random_config;
    logic [15:0] lo;
    logic [15:0] hi;
    lo = 16'($urandom_range(0, 65535));
    case ($urandom_range(0, 7))
      0: begin
        lo = 16'd0;
        hi = 16'hFFFF;
      end
      1: hi = (lo == 16'd0) ? 16'd0 : lo - 16'd1;
      default: hi = (lo > 16'd62535) ? 16'hFFFF : lo + 16'($urandom_range(0, 3000));
    endcase
    write_reg(REG_MAGIC, $urandom);
    write_reg(REG_VERSION, $urandom);
    write_reg(REG_CHECK_VERSION, $urandom);
    write_reg(REG_TYPE_LOWEST, {16'($urandom), lo});
    write_reg(REG_TYPE_HIGHEST, {16'($urandom), hi});
    if ($urandom_range(0, 1) == 0) begin
      write_reg(REG_PAYLOAD_LIMIT, $urandom_range(0, 40));
    end else begin
      write_reg(REG_PAYLOAD_LIMIT, $urandom);
    end
  endtask

  task automatic random_phase(input int n_bytes, input int max_pay);
    int start;
    start = bytes_pending.size();
    while (bytes_pending.size() - start < n_bytes) queue_random_frame(max_pay);
  endtask

  // Stimulus sequence.
  initial begin : run_phases
    frame_hdr_t h;
    rst            = 1'b1;
    pkt_ch.valid   = 1'b0;
    pkt_ch.data_byte = 8'd0;
    pkt_ch.last_byte = 1'b0;
    res_ch.ready   = 1'b0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = '0;
    cfg_ch.data    = '0;
    want_magic     = 32'd0;
    want_version   = 16'd0;
    want_check_ver = 1'b1;
    want_type_lo   = 16'd0;
    want_type_hi   = 16'd24;
    want_limit     = 16'd1024;
    frame_count    = '0;
    frame_hash     = FnvStart;
    mismatches     = 0;
    words_seen     = 0;
    bytes_taken    = 0;
    hold_from      = 0;
    set_idling(5, 5);
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Register values out of reset.
    h = good_hdr(0);
    h.ptype = 16'd0;
    queue_frame(h, 0, 1'b0, 0);
    h = good_hdr(4);
    h.ptype = 16'd24;
    queue_frame(h, int'(h.len_field), 1'b0, 0);
    h = good_hdr(3);
    h.ptype = 16'd25;
    queue_frame(h, int'(h.len_field), 1'b0, 0);
    h = good_hdr(3);
    h.ver = 16'd1;
    queue_frame(h, int'(h.len_field), 1'b0, 0);
    // Bad magic outranks a version mismatch; a mismatch outranks the checksum.
    h = good_hdr(3);
    h.magic = 32'h8000_0000;
    h.ver = 16'd1;
    queue_frame(h, int'(h.len_field), 1'b0, 0);
    h = good_hdr(3);
    h.ver = 16'd2;
    queue_frame(h, int'(h.len_field), 1'b1, 0);
    // Short frames: a single byte, and one byte short of a header.
    h = good_hdr(3);
    queue_frame(h, 0, 1'b0, 1);
    queue_frame(h, 3, 1'b0, HeaderLen - 1);
    h = good_hdr(5);
    queue_frame(h, int'(h.len_field), 1'b1, 0);
    // Length field disagreeing with the byte count either way.
    h = good_hdr(4);
    h.len_field = 16'd2;
    queue_frame(h, 3, 1'b0, 0);
    h.len_field = 16'd3;
    queue_frame(h, 2, 1'b0, 0);
    settle();

    // All-ones registers, type window from 100 up to the top, zero payload limit.
    write_reg(REG_MAGIC, 32'hFFFF_FFFF);
    write_reg(REG_VERSION, 32'hFFFF_FFFF);
    write_reg(REG_CHECK_VERSION, 32'd1);
    write_reg(REG_TYPE_LOWEST, 32'd100);
    write_reg(REG_TYPE_HIGHEST, 32'hFFFF_FFFF);
    write_reg(REG_PAYLOAD_LIMIT, 32'd0);
    write_reg(RegSpareLo, $urandom);
    write_reg(RegSpareHi, $urandom);
    h = good_hdr(0);
    h.ptype   = 16'hFFFF;
    h.session = '1;
    h.player  = '1;
    h.flags   = '1;
    h.seqno   = '1;
    h.frame   = '1;
    queue_frame(h, 0, 1'b0, 0);
    h = good_hdr(0);
    h.ptype   = 16'd100;
    h.session = '0;
    h.player  = '0;
    h.flags   = '0;
    h.seqno   = '0;
    h.frame   = '0;
    queue_frame(h, 0, 1'b0, 0);
    h.ptype = 16'd99;
    queue_frame(h, 0, 1'b0, 0);
    // Payload one over the limit.
    h = good_hdr(0);
    h.len_field = 16'd1;
    queue_frame(h, 1, 1'b0, 0);
    settle();

    // Empty type window: every frame is malformed.
    write_reg(REG_MAGIC, 32'd0);
    write_reg(REG_VERSION, 32'h1234);
    write_reg(REG_CHECK_VERSION, 32'd0);
    write_reg(REG_TYPE_LOWEST, 32'd5);
    write_reg(REG_TYPE_HIGHEST, 32'd4);
    write_reg(REG_PAYLOAD_LIMIT, 32'hFFFF);
    h = good_hdr(2);
    h.ptype = 16'd4;
    queue_frame(h, int'(h.len_field), 1'b0, 0);
    h.ptype = 16'd5;
    queue_frame(h, int'(h.len_field), 1'b0, 0);
    settle();

    // Full type window with version checking off: any version passes.
    write_reg(REG_TYPE_LOWEST, 32'd0);
    write_reg(REG_TYPE_HIGHEST, 32'hFFFF);
    h = good_hdr(3);
    h.ver = 16'hFFFF;
    queue_frame(h, int'(h.len_field), 1'b0, 0);
    h = good_hdr(3);
    h.ver = 16'd0;
    queue_frame(h, int'(h.len_field), 1'b0, 0);
    settle();

    // Random frames; the first phase also carries the long receiver hold-off.
    random_config();
    set_idling(4, 4);
    hold_from = bytes_taken + 20;
    random_phase(150, 40);
    settle();
    random_config();
    set_idling(0, 3);
    random_phase(100, 16);
    settle();
    random_config();
    set_idling(3, 0);
    random_phase(100, 16);
    settle();
    random_config();
    set_idling(2, 2);
    random_phase(100, 16);
    settle();
    random_config();
    set_idling(0, 0);
    random_phase(100, 16);
    settle();

    if (mismatches == 0) begin
      $display("PASS packet_frame_checker_unit");
    end else begin
      $display("FAIL packet_frame_checker_unit");
    end
    $finish;
  end

endmodule

[files.f]
sv/pfc_pkg.sv
sv/pfc_in_if.sv
sv/pfc_out_if.sv
sv/pfc_cfg_if.sv
sv/packet_frame_checker_unit.sv
dv/tb_packet_frame_checker_unit.sv
